>>> hdl/spmq_pkg.sv
// ----------------------------------------------------------------------------
// spmq_pkg
// Shared types and constants for the stable priority message queue.
// ----------------------------------------------------------------------------
package spmq_pkg;

	// fixed field widths
	localparam int LEN_W   = 14;	// stored message length
	localparam int TAG_W   = 32;	// payload handle
	localparam int BYTES_W = 20;	// byte total, wraps
	localparam int MSG_W   = 7;	// max_messages register
	localparam int REG_W   = 14;	// widest config register

	// config register indexes
	localparam logic REG_MAX_MESSAGES     = 1'b0;
	localparam logic REG_MAX_MESSAGE_BYTES = 1'b1;

	// request opcodes
	typedef enum logic [2:0] {
		OP_SEND       = 3'd0,
		OP_RECEIVE    = 3'd1,
		OP_ARM_SIGNAL = 3'd2,
		OP_ARM_SILENT = 3'd3,
		OP_DISARM     = 3'd4
	} spmq_op_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_FULL    = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_BADPRIO = 3'd3,
		ST_SIZE    = 3'd4
	} spmq_status_t;

	// control broadcast to every cell of the row
	typedef struct packed {
		logic push;	// insert the new entry in priority order
		logic pop;	// shift every entry one place toward the head
	} spmq_ctl_t;

endpackage

>>> hdl/spmq_cell.sv
// ----------------------------------------------------------------------------
// spmq_cell
// One slot of the sorted entry row. Keeps its entry, takes the new entry,
// or takes a neighbor's entry so that the row stays ordered.
// ----------------------------------------------------------------------------
module spmq_cell import spmq_pkg::*; #(
	parameter int PRIO_W = 5,
	parameter int CNT_W  = 7,
	parameter int IDX    = 0
) (
	input  logic               clk,
	input  spmq_ctl_t          ctl,
	input  logic [CNT_W-1:0]   count,
	input  logic [PRIO_W-1:0]  new_prio,
	input  logic [LEN_W-1:0]   new_len,
	input  logic [TAG_W-1:0]   new_tag,
	input  logic               left_ge,
	input  logic [PRIO_W-1:0]  left_prio,
	input  logic [LEN_W-1:0]   left_len,
	input  logic [TAG_W-1:0]   left_tag,
	input  logic [PRIO_W-1:0]  right_prio,
	input  logic [LEN_W-1:0]   right_len,
	input  logic [TAG_W-1:0]   right_tag,
	output logic               ge,
	output logic [PRIO_W-1:0]  prio,
	output logic [LEN_W-1:0]   len,
	output logic [TAG_W-1:0]   tag
);

	logic [PRIO_W-1:0] prio_q;
	logic [LEN_W-1:0]  len_q;
	logic [TAG_W-1:0]  tag_q;
	logic              occupied;

	// held entry that stays ahead of a new one of this priority
	assign occupied = CNT_W'(IDX) < count;
	assign ge       = occupied && (prio_q >= new_prio);

	// entry update: shift toward head on pop, make room on push
	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			prio_q <= right_prio;
			len_q  <= right_len;
			tag_q  <= right_tag;
		end else if (ctl.push && !ge) begin
			if (left_ge) begin
				prio_q <= new_prio;
				len_q  <= new_len;
				tag_q  <= new_tag;
			end else begin
				prio_q <= left_prio;
				len_q  <= left_len;
				tag_q  <= left_tag;
			end
		end
	end

	assign prio = prio_q;
	assign len  = len_q;
	assign tag  = tag_q;

endmodule

>>> hdl/stable_priority_message_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_message_queue
// Bounded message queue kept in a row of cells, highest priority at the
// head, first in first out within one priority. Send, receive, notify.
// ----------------------------------------------------------------------------
// Result: registered; it appears on the master side in the cycle after the item is accepted.
// Throughput: one item per cycle while m_tready is high; the cell row inserts or pops as
//   the item is accepted, and the output register frees the input while a result is taken.
// Reset: clears message count, byte total, notification and output valid, loads the config
//   registers with their defaults; entry cells hold no reset value.
// ----------------------------------------------------------------------------
module stable_priority_message_queue import spmq_pkg::*; #(
	parameter  int DEPTH       = 64,
	parameter  int PRIO_LEVELS = 32,
	parameter  int MAX_BYTES   = 8192,
	localparam int PRIO_W      = $clog2(PRIO_LEVELS),
	localparam int CNT_W       = $clog2(DEPTH + 1),
	localparam int OUT_BITS    = PRIO_W + LEN_W + TAG_W + 1 + CNT_W + BYTES_W,
	localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	// configuration writes
	input  logic             cfg_we,
	input  logic             cfg_addr,
	input  logic [REG_W-1:0] cfg_wdata,
	// requests
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [71:0]      s_tdata,	// priority_req, length, payload_tag, reader_waiting
	input  logic [2:0]       s_tuser,	// opcode
	// results
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,	// out_priority, out_length, out_tag, notify_fire,
						// message_count, byte_count
	output logic [2:0]       m_tuser	// status
);

	localparam int LIM_W = (CNT_W > MSG_W) ? CNT_W : MSG_W;
	localparam int BL_W  = 17;

	// request fields
	logic [15:0]      req_prio;
	logic [15:0]      req_len;
	logic [TAG_W-1:0] req_tag;
	logic             req_waiting;
	spmq_op_t         req_op;
	logic             accept;

	assign req_prio    = s_tdata[15:0];
	assign req_len     = s_tdata[31:16];
	assign req_tag     = s_tdata[63:32];
	assign req_waiting = s_tdata[64];
	assign req_op      = spmq_op_t'(s_tuser);

	// control state
	logic [MSG_W-1:0]   max_messages_q;
	logic [REG_W-1:0]   max_message_bytes_q;
	logic [CNT_W-1:0]   count_q;
	logic [BYTES_W-1:0] bytes_q;
	logic               armed_q;
	logic               signals_q;
	logic               out_valid_q;

	// result registers
	spmq_status_t       status_q;
	logic [PRIO_W-1:0]  out_prio_q;
	logic [LEN_W-1:0]   out_len_q;
	logic [TAG_W-1:0]   out_tag_q;
	logic               fire_q;

	// cell row wiring, one extra slot past the tail feeds zeros on pop
	logic [DEPTH-1:0]  cell_ge;
	logic [PRIO_W-1:0] cell_prio [DEPTH+1];
	logic [LEN_W-1:0]  cell_len  [DEPTH+1];
	logic [TAG_W-1:0]  cell_tag  [DEPTH+1];
	spmq_ctl_t         ctl;

	// next-state decision
	spmq_status_t       status_d;
	logic               fire_d;
	logic               armed_d;
	logic               signals_d;
	logic [CNT_W-1:0]   count_d;
	logic [BYTES_W-1:0] bytes_d;
	logic [BL_W-1:0]    lim_bytes;
	logic               full;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// effective limits
	assign lim_bytes = (BL_W'(max_message_bytes_q) < BL_W'(MAX_BYTES)) ?
	                   BL_W'(max_message_bytes_q) : BL_W'(MAX_BYTES);
	assign full = (count_q >= CNT_W'(DEPTH)) ||
	              (LIM_W'(count_q) >= LIM_W'(max_messages_q));

	// request decode
	always_comb begin
		ctl       = '0;
		status_d  = ST_OK;
		fire_d    = 1'b0;
		armed_d   = armed_q;
		signals_d = signals_q;
		count_d   = count_q;
		bytes_d   = bytes_q;
		unique case (req_op)
			OP_SEND: begin
				if (17'(req_prio) >= 17'(PRIO_LEVELS)) begin
					status_d = ST_BADPRIO;
				end else if (BL_W'(req_len) > lim_bytes) begin
					status_d = ST_SIZE;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					ctl.push = 1'b1;
					count_d  = count_q + 1'b1;
					bytes_d  = bytes_q + BYTES_W'(req_len);
					// empty to non-empty with no reader: one-shot notify
					if (count_q == '0 && armed_q && !req_waiting) begin
						fire_d    = signals_q;
						armed_d   = 1'b0;
						signals_d = 1'b0;
					end
				end
			end
			OP_RECEIVE: begin
				if (BL_W'(req_len) < lim_bytes) begin
					status_d = ST_SIZE;
				end else if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					ctl.pop = 1'b1;
					count_d = count_q - 1'b1;
					bytes_d = bytes_q - BYTES_W'(cell_len[0]);
				end
			end
			OP_ARM_SIGNAL: begin
				armed_d   = 1'b1;
				signals_d = 1'b1;
			end
			OP_ARM_SILENT: begin
				armed_d   = 1'b1;
				signals_d = 1'b0;
			end
			OP_DISARM: begin
				armed_d   = 1'b0;
				signals_d = 1'b0;
			end
			default: begin
			end
		endcase
		if (!accept) begin
			ctl = '0;
		end
	end

	// row of entry cells
	assign cell_prio[DEPTH] = '0;
	assign cell_len[DEPTH]  = '0;
	assign cell_tag[DEPTH]  = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic              l_ge;
		logic [PRIO_W-1:0] l_prio;
		logic [LEN_W-1:0]  l_len;
		logic [TAG_W-1:0]  l_tag;

		if (i == 0) begin : g_head
			assign l_ge   = 1'b1;
			assign l_prio = '0;
			assign l_len  = '0;
			assign l_tag  = '0;
		end else begin : g_body
			assign l_ge   = cell_ge[i-1];
			assign l_prio = cell_prio[i-1];
			assign l_len  = cell_len[i-1];
			assign l_tag  = cell_tag[i-1];
		end

		spmq_cell #(
			.PRIO_W (PRIO_W),
			.CNT_W  (CNT_W),
			.IDX    (i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.count      (count_q),
			.new_prio   (req_prio[PRIO_W-1:0]),
			.new_len    (req_len[LEN_W-1:0]),
			.new_tag    (req_tag),
			.left_ge    (l_ge),
			.left_prio  (l_prio),
			.left_len   (l_len),
			.left_tag   (l_tag),
			.right_prio (cell_prio[i+1]),
			.right_len  (cell_len[i+1]),
			.right_tag  (cell_tag[i+1]),
			.ge         (cell_ge[i]),
			.prio       (cell_prio[i]),
			.len        (cell_len[i]),
			.tag        (cell_tag[i])
		);
	end

	// config, counters, notification, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_messages_q      <= MSG_W'(10);
			max_message_bytes_q <= REG_W'(8192);
			count_q             <= '0;
			bytes_q             <= '0;
			armed_q             <= 1'b0;
			signals_q           <= 1'b0;
			out_valid_q         <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_MAX_MESSAGES:      max_messages_q      <= cfg_wdata[MSG_W-1:0];
					REG_MAX_MESSAGE_BYTES: max_message_bytes_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
			if (accept) begin
				count_q     <= count_d;
				bytes_q     <= bytes_d;
				armed_q     <= armed_d;
				signals_q   <= signals_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			fire_q   <= fire_d;
			if (ctl.pop) begin
				out_prio_q <= cell_prio[0];
				out_len_q  <= cell_len[0];
				out_tag_q  <= cell_tag[0];
			end else begin
				out_prio_q <= '0;
				out_len_q  <= '0;
				out_tag_q  <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = OUT_W'({bytes_q, count_q, fire_q, out_tag_q, out_len_q, out_prio_q});

endmodule
